// File: design/jrbs_pkg.sv
// shared types and constants for the job retry backoff scheduler
package jrbs_pkg;

    localparam int OP_ID_BITS_DEF = 16;
    localparam int MAX_SHIFT_DEF  = 4;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_JOB_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_BACKOFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFF  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FETCH_PERIOD = 2'd3;

    localparam logic [31:0] JOB_TIMEOUT_RST  = 32'd10000;
    localparam logic [31:0] BASE_BACKOFF_RST = 32'd5000;
    localparam logic [31:0] MAX_BACKOFF_RST  = 32'd300000;
    localparam logic [31:0] FETCH_PERIOD_RST = 32'd600000;

    localparam logic [1:0] CMD_POLL         = 2'd0;
    localparam logic [1:0] CMD_POLL_OUTCOME = 2'd1;
    localparam logic [1:0] CMD_SET_LOCATION = 2'd2;

    localparam logic [1:0] JOB_NONE   = 2'd0;
    localparam logic [1:0] JOB_LOCATE = 2'd1;
    localparam logic [1:0] JOB_FETCH  = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_FAILED  = 2'd2;

    localparam logic KIND_LOCATE = 1'b0;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_ms;
        logic        outcome_ok;
        logic        outcome_kind;
        logic [15:0] outcome_op_id;
        logic [31:0] outcome_latency_ms;
        logic        location_present;
    } t_sched_in;

    typedef struct packed {
        logic [2:0]  net_state;
        logic [1:0]  issue_job;
        logic [15:0] issued_op_id;
        logic [1:0]  error_class;
        logic [15:0] failure_count;
        logic [31:0] current_backoff_ms;
        logic        remote_online;
        logic        location_known;
        logic        data_valid;
        logic [31:0] last_latency_ms;
    } t_sched_out;

endpackage

// File: design/job_retry_backoff_scheduler_unit.sv
// job retry backoff scheduler: one registered pass per item
// an item passes through the input register, then the result register
// throughput: one item per cycle unless the output stalls; the scheduler state updates in the
// same cycle as the result register loads, so each item sees the state left by the one before
// reset (synchronous, active low) clears the scheduler state and loads the default timing values
module job_retry_backoff_scheduler_unit #(
    parameter int OP_ID_BITS = jrbs_pkg::OP_ID_BITS_DEF,
    parameter int MAX_SHIFT  = jrbs_pkg::MAX_SHIFT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  jrbs_pkg::t_sched_in            i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output jrbs_pkg::t_sched_out           o_out,
    input  logic                           i_cfg_we,
    input  logic [jrbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [jrbs_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int CMP_W  = (OP_ID_BITS > 16) ? OP_ID_BITS : 16;
    localparam int SH_W   = $clog2(MAX_SHIFT + 2);
    localparam int WIDE_W = 32 + MAX_SHIFT;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_BACKOFF  = 3'd1,
        MODE_INTERVAL = 3'd2,
        MODE_LOCATING = 3'd3,
        MODE_FETCHING = 3'd4
    } t_mode;

    // configuration
    logic [31:0] r_job_timeout, r_base_backoff, r_max_backoff, r_fetch_period;

    // pipeline
    logic                 r_in_valid, r_out_valid;
    jrbs_pkg::t_sched_in  r_in;
    jrbs_pkg::t_sched_out r_out, n_out;
    logic                 stage_go;

    // scheduler state
    t_mode                 r_mode, n_mode;
    logic                  r_in_flight, n_in_flight;
    logic [31:0]           r_flight_start, n_flight_start;
    logic [OP_ID_BITS-1:0] r_active_id, n_active_id;
    logic [OP_ID_BITS-1:0] r_next_id, n_next_id;
    logic [15:0]           r_failures, n_failures;
    logic [31:0]           r_backoff, n_backoff;
    logic [31:0]           r_next_attempt, n_next_attempt;
    logic [31:0]           r_last_fetch, n_last_fetch;
    logic                  r_need_locate, n_need_locate;
    logic                  r_have_location, n_have_location;
    logic                  r_location_set, n_location_set;
    logic                  r_online, n_online;
    logic                  r_data_valid, n_data_valid;
    logic [31:0]           r_latency, n_latency;

    // failure path values, from the count before this item
    logic [15:0]       fail_count;
    logic [SH_W-1:0]   fail_shift;
    logic [WIDE_W-1:0] fail_wide;
    logic [31:0]       fail_backoff;

    logic        accepted;
    logic        timed_out;
    logic [1:0]  issue;
    logic [1:0]  err;
    logic [31:0] now;

    assign stage_go    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || stage_go;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign now         = r_in.now_ms;

    always_comb begin
        fail_count = (r_failures == 16'hFFFF) ? r_failures : r_failures + 16'd1;
        // shift is min(MAX_SHIFT, failures - 1) with failures already bumped
        if (r_failures >= 16'(MAX_SHIFT)) begin
            fail_shift = SH_W'(MAX_SHIFT);
        end else begin
            fail_shift = r_failures[SH_W-1:0];
        end
        fail_wide = WIDE_W'(r_base_backoff) << fail_shift;
        if (fail_wide > WIDE_W'(r_max_backoff)) begin
            fail_backoff = r_max_backoff;
        end else begin
            fail_backoff = fail_wide[31:0];
        end
    end

    always_comb begin
        n_mode          = r_mode;
        n_in_flight     = r_in_flight;
        n_flight_start  = r_flight_start;
        n_active_id     = r_active_id;
        n_next_id       = r_next_id;
        n_failures      = r_failures;
        n_backoff       = r_backoff;
        n_next_attempt  = r_next_attempt;
        n_last_fetch    = r_last_fetch;
        n_need_locate   = r_need_locate;
        n_have_location = r_have_location;
        n_location_set  = r_location_set;
        n_online        = r_online;
        n_data_valid    = r_data_valid;
        n_latency       = r_latency;
        issue           = jrbs_pkg::JOB_NONE;
        err             = jrbs_pkg::ERR_NONE;
        accepted        = 1'b0;
        timed_out       = 1'b0;

        if (r_in.command == jrbs_pkg::CMD_SET_LOCATION) begin
            n_location_set = r_in.location_present;
            n_need_locate  = r_in.location_present;
            if (r_in.location_present) begin
                n_have_location = 1'b0;
                n_next_attempt  = '0;
                n_failures      = '0;
                n_backoff       = '0;
            end
        end else begin
            accepted = (r_in.command == jrbs_pkg::CMD_POLL_OUTCOME) && r_in_flight &&
                       (CMP_W'(r_in.outcome_op_id) == CMP_W'(r_active_id));
            timed_out = !accepted && r_in_flight &&
                        ((now - r_flight_start) > r_job_timeout);
            if (accepted) begin
                n_in_flight = 1'b0;
                n_latency   = r_in.outcome_latency_ms;
                if (!r_in.outcome_ok) begin
                    n_online       = 1'b0;
                    n_failures     = fail_count;
                    n_backoff      = fail_backoff;
                    n_next_attempt = now + fail_backoff;
                    n_mode         = MODE_BACKOFF;
                    err            = jrbs_pkg::ERR_FAILED;
                end else begin
                    n_failures = '0;
                    n_backoff  = '0;
                    n_mode     = MODE_IDLE;
                    if (r_in.outcome_kind == jrbs_pkg::KIND_LOCATE) begin
                        n_need_locate   = 1'b0;
                        n_have_location = 1'b1;
                        n_last_fetch    = '0;
                        n_next_attempt  = now;
                    end else begin
                        n_data_valid   = 1'b1;
                        n_online       = 1'b1;
                        n_last_fetch   = now;
                        n_next_attempt = now + r_fetch_period;
                    end
                end
            end else if (timed_out) begin
                n_failures     = fail_count;
                n_backoff      = fail_backoff;
                n_next_attempt = now + fail_backoff;
                n_mode         = MODE_BACKOFF;
                err            = jrbs_pkg::ERR_TIMEOUT;
                n_in_flight    = 1'b0;
                n_active_id    = '0;
            end

            if (!n_in_flight) begin
                if (n_next_attempt != '0 && now < n_next_attempt) begin
                    n_mode = (n_failures != '0 || n_backoff != '0) ? MODE_BACKOFF
                                                                   : MODE_INTERVAL;
                end else if (n_need_locate && n_location_set) begin
                    issue          = jrbs_pkg::JOB_LOCATE;
                    n_active_id    = r_next_id;
                    n_next_id      = r_next_id + OP_ID_BITS'(1);
                    n_in_flight    = 1'b1;
                    n_flight_start = now;
                    n_mode         = MODE_LOCATING;
                end else if (n_have_location && (n_last_fetch == '0 ||
                             (now - n_last_fetch) >= r_fetch_period)) begin
                    issue          = jrbs_pkg::JOB_FETCH;
                    n_active_id    = r_next_id;
                    n_next_id      = r_next_id + OP_ID_BITS'(1);
                    n_in_flight    = 1'b1;
                    n_flight_start = now;
                    n_mode         = MODE_FETCHING;
                end else begin
                    n_mode = MODE_IDLE;
                end
            end
        end

        n_out.net_state          = 3'(n_mode);
        n_out.issue_job          = issue;
        n_out.issued_op_id       = n_in_flight ? 16'(n_active_id) : '0;
        n_out.error_class        = err;
        n_out.failure_count      = n_failures;
        n_out.current_backoff_ms = n_backoff;
        n_out.remote_online      = n_online;
        n_out.location_known     = n_have_location;
        n_out.data_valid         = n_data_valid;
        n_out.last_latency_ms    = n_latency;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_job_timeout   <= jrbs_pkg::JOB_TIMEOUT_RST;
            r_base_backoff  <= jrbs_pkg::BASE_BACKOFF_RST;
            r_max_backoff   <= jrbs_pkg::MAX_BACKOFF_RST;
            r_fetch_period  <= jrbs_pkg::FETCH_PERIOD_RST;
            r_mode          <= MODE_IDLE;
            r_in_flight     <= 1'b0;
            r_flight_start  <= '0;
            r_active_id     <= '0;
            r_next_id       <= OP_ID_BITS'(1);
            r_failures      <= '0;
            r_backoff       <= '0;
            r_next_attempt  <= '0;
            r_last_fetch    <= '0;
            r_need_locate   <= 1'b0;
            r_have_location <= 1'b0;
            r_location_set  <= 1'b0;
            r_online        <= 1'b0;
            r_data_valid    <= 1'b0;
            r_latency       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    jrbs_pkg::CFG_JOB_TIMEOUT:  r_job_timeout  <= i_cfg_wdata;
                    jrbs_pkg::CFG_BASE_BACKOFF: r_base_backoff <= i_cfg_wdata;
                    jrbs_pkg::CFG_MAX_BACKOFF:  r_max_backoff  <= i_cfg_wdata;
                    jrbs_pkg::CFG_FETCH_PERIOD: r_fetch_period <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                if (i_in_valid) begin
                    r_in <= i_in;
                end
            end

            if (stage_go) begin
                r_out_valid     <= 1'b1;
                r_out           <= n_out;
                r_mode          <= n_mode;
                r_in_flight     <= n_in_flight;
                r_flight_start  <= n_flight_start;
                r_active_id     <= n_active_id;
                r_next_id       <= n_next_id;
                r_failures      <= n_failures;
                r_backoff       <= n_backoff;
                r_next_attempt  <= n_next_attempt;
                r_last_fetch    <= n_last_fetch;
                r_need_locate   <= n_need_locate;
                r_have_location <= n_have_location;
                r_location_set  <= n_location_set;
                r_online        <= n_online;
                r_data_valid    <= n_data_valid;
                r_latency       <= n_latency;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
